// File: design/assert_macros.svh
// Assertion macros used by the checker file.
// Uses the clk and rst_n names of the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define RQS_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqs check failed");

// ante implies cons in the next cycle
`define RQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rqs check failed");

`endif

// File: design/rqs_pkg.sv
// Types and constants of the ready queue thread scheduler.
// No dependencies; used by every other file but assert_macros.svh.
`default_nettype none

package rqs_pkg;

    localparam int SLOT_W    = 4;
    localparam int SLOT_N    = 16;
    localparam int CMD_W     = 3;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT = 2'd1;

    localparam logic [KIND_W-1:0] KIND_BLOCKED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAITING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HANGING = 2'd2;

    typedef enum logic [2:0] {
        ST_RUNNING = 3'd0,
        ST_READY   = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_WAITING = 3'd3,
        ST_HANGING = 3'd4,
        ST_DIED    = 3'd5
    } stat_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 3'd0,
        CMD_YIELD   = 3'd1,
        CMD_BLOCK   = 3'd2,
        CMD_UNBLOCK = 3'd3,
        CMD_EXIT    = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_REMOVE,
        S_REM_FIX,
        S_PASS,
        S_INS_A,
        S_INS_B,
        S_IDLE_RD,
        S_IDLE_CHK,
        S_POP_RD,
        S_POP,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        logic [SLOT_W-1:0] next;
        logic [SLOT_W-1:0] prev;
    } link_word_t;

    typedef struct packed {
        logic              stat_re;
        logic [SLOT_W-1:0] stat_raddr;
        logic              stat_we;
        logic [SLOT_W-1:0] stat_waddr;
        stat_t             stat_wdata;
        logic              link_re;
        logic [SLOT_W-1:0] link_raddr;
        logic              link_we_next;
        logic              link_we_prev;
        logic [SLOT_W-1:0] link_waddr;
        link_word_t        link_wdata;
    } mem_req_t;

    typedef struct packed {
        stat_t      stat;
        link_word_t link;
    } mem_rsp_t;

    typedef struct packed {
        logic [SLOT_W-1:0] idle_slot;
        logic [SLOT_W-1:0] boot_slot;
        logic              reload;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0] running_slot;
        logic [SLOT_W-1:0] previous_slot;
        logic              switched;
        logic              outcome;
    } res_t;

endpackage

`default_nettype wire

// File: design/rqs_cmd_if.sv
// Command channel of the scheduler.
// Depends on rqs_pkg.
`default_nettype none

interface rqs_cmd_if import rqs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] thread_slot;
    logic [KIND_W-1:0] block_kind;
    logic              reschedule;

    modport source (output valid, command, thread_slot, block_kind, reschedule,
                    input ready);
    modport sink   (input valid, command, thread_slot, block_kind, reschedule,
                    output ready);
endinterface

`default_nettype wire

// File: design/rqs_res_if.sv
// Result channel of the scheduler.
// Depends on rqs_pkg.
`default_nettype none

interface rqs_res_if import rqs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] running_slot;
    logic [SLOT_W-1:0] previous_slot;
    logic              switched;
    logic              outcome;

    modport source (output valid, running_slot, previous_slot, switched, outcome,
                    input ready);
    modport sink   (input valid, running_slot, previous_slot, switched, outcome,
                    output ready);
endinterface

`default_nettype wire

// File: design/rqs_cfg_if.sv
// Configuration write channel of the scheduler.
// Depends on rqs_pkg.
`default_nettype none

interface rqs_cfg_if import rqs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SLOT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/rqs_cfg.sv
// Configuration registers idle_slot and boot_slot with reload request.
// Depends on rqs_pkg and rqs_cfg_if.
`default_nettype none

module rqs_cfg import rqs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rqs_cfg_if.sink   cfg,
    output cfg_t      cfg_st
);

    logic [SLOT_W-1:0] idle_reg, idle_next;
    logic [SLOT_W-1:0] boot_reg, boot_next;
    logic              reload_reg, reload_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        idle_next   = idle_reg;
        boot_next   = boot_reg;
        reload_next = 1'b0;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_IDLE:
                begin
                    idle_next   = cfg.data;
                    reload_next = 1'b1;
                end
                CFG_BOOT:
                begin
                    boot_next   = cfg.data;
                    reload_next = 1'b1;
                end
                default:
                begin
                    reload_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg   <= SLOT_W'(1);
            boot_reg   <= '0;
            reload_reg <= 1'b0;
        end
        else
        begin
            idle_reg   <= idle_next;
            boot_reg   <= boot_next;
            reload_reg <= reload_next;
        end
    end

    assign cfg_st.idle_slot = idle_reg;
    assign cfg_st.boot_slot = boot_reg;
    assign cfg_st.reload    = reload_reg;

endmodule

`default_nettype wire

// File: design/rqs_store.sv
// Slot status memory and ready queue link memory, each with a registered read.
// Depends on rqs_pkg.
`default_nettype none

module rqs_store import rqs_pkg::*;
#(
    parameter int MAX_THREADS = 16
)
(
    input  wire logic clk,
    input  mem_req_t  req,
    output mem_rsp_t  rsp
);

    localparam int DEPTH = (MAX_THREADS < SLOT_N) ? MAX_THREADS : SLOT_N;
    localparam int IW    = $clog2(DEPTH);

    stat_t              stat_mem [DEPTH];
    logic [1:0][IW-1:0] link_mem [DEPTH];
    stat_t              stat_rd_reg;
    logic [1:0][IW-1:0] link_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.stat_we)
        begin
            stat_mem[req.stat_waddr[IW-1:0]] <= req.stat_wdata;
        end
        if (req.stat_re)
        begin
            stat_rd_reg <= stat_mem[req.stat_raddr[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.link_we_next)
        begin
            link_mem[req.link_waddr[IW-1:0]][1] <= req.link_wdata.next[IW-1:0];
        end
        if (req.link_we_prev)
        begin
            link_mem[req.link_waddr[IW-1:0]][0] <= req.link_wdata.prev[IW-1:0];
        end
        if (req.link_re)
        begin
            link_rd_reg <= link_mem[req.link_raddr[IW-1:0]];
        end
    end

    assign rsp.stat      = stat_rd_reg;
    assign rsp.link.next = SLOT_W'(link_rd_reg[1]);
    assign rsp.link.prev = SLOT_W'(link_rd_reg[0]);

endmodule

`default_nettype wire

// File: design/rqs_engine.sv
// Command sequencer: read-modify-write of slot status and queue links.
// Depends on rqs_pkg, rqs_cmd_if; drives rqs_store through mem_req_t.
`default_nettype none

module rqs_engine import rqs_pkg::*;
#(
    parameter int MAX_THREADS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    rqs_cmd_if.sink   cmd,
    input  cfg_t      cfg_st,
    input  mem_rsp_t  rsp,
    output mem_req_t  req,
    input  wire logic out_free,
    output logic      res_load,
    output res_t      res_data
);

    localparam int DEPTH = (MAX_THREADS < SLOT_N) ? MAX_THREADS : SLOT_N;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    eng_state_t        state_reg, state_next;
    eng_state_t        ret_reg, ret_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              resched_reg, resched_next;
    logic [SLOT_W-1:0] prev_reg, prev_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0] ins_reg, ins_next;
    logic              push_reg, push_next;
    logic              sw_reg, sw_next;
    logic              bad_reg, bad_next;
    logic [IW-1:0]     clr_reg, clr_next;

    logic [SLOT_W-1:0] tgt;
    stat_t             tgt_st;
    logic [SLOT_W-1:0] clr_slot;

    function automatic logic in_rng(input logic [SLOT_W-1:0] s);
        return int'(s) < MAX_THREADS;
    endfunction

    function automatic logic parked(input stat_t s);
        return s == ST_BLOCKED || s == ST_WAITING || s == ST_HANGING;
    endfunction

    function automatic logic uses_slot(input logic [CMD_W-1:0] c);
        return cmd_t'(c) == CMD_START || cmd_t'(c) == CMD_UNBLOCK || cmd_t'(c) == CMD_EXIT;
    endfunction

    function automatic stat_t block_stat(input logic [KIND_W-1:0] k);
        stat_t r;
        case (k)
            KIND_BLOCKED: r = ST_BLOCKED;
            KIND_WAITING: r = ST_WAITING;
            default:      r = ST_HANGING;
        endcase
        return r;
    endfunction

    assign tgt      = uses_slot(cmd_reg) ? slot_reg : cur_reg;
    assign tgt_st   = in_rng(tgt) ? rsp.stat : ST_DIED;
    assign clr_slot = SLOT_W'(clr_reg);

    assign res_data.running_slot  = cur_reg;
    assign res_data.previous_slot = prev_reg;
    assign res_data.switched      = sw_reg;
    assign res_data.outcome       = bad_reg;

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cmd_next     = cmd_reg;
        slot_next    = slot_reg;
        kind_next    = kind_reg;
        resched_next = resched_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        ins_next     = ins_reg;
        push_next    = push_reg;
        sw_next      = sw_reg;
        bad_next     = bad_reg;
        clr_next     = clr_reg;
        req          = '0;
        cmd.ready    = 1'b0;
        res_load     = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                req.stat_we    = 1'b1;
                req.stat_waddr = clr_slot;
                if (clr_slot == cfg_st.boot_slot)
                    req.stat_wdata = ST_RUNNING;
                else if (clr_slot == cfg_st.idle_slot)
                    req.stat_wdata = ST_BLOCKED;
                else
                    req.stat_wdata = ST_DIED;
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                cur_next   = cfg_st.boot_slot;
                clr_next   = clr_reg + IW'(1);
                if (clr_reg == IW'(DEPTH - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                // a pending reload takes over the next cycle
                cmd.ready = !cfg_st.reload;
                if (cmd.valid && !cfg_st.reload)
                begin
                    cmd_next       = cmd.command;
                    slot_next      = cmd.thread_slot;
                    kind_next      = cmd.block_kind;
                    resched_next   = cmd.reschedule;
                    prev_next      = cur_reg;
                    sw_next        = 1'b0;
                    bad_next       = 1'b0;
                    req.stat_re    = 1'b1;
                    req.stat_raddr = uses_slot(cmd.command) ? cmd.thread_slot : cur_reg;
                    state_next     = S_CHECK;
                end
            end

            S_CHECK:
            begin
                state_next = S_DONE;
                case (cmd_t'(cmd_reg))
                    CMD_START:
                    begin
                        if (in_rng(slot_reg) && tgt_st == ST_DIED)
                        begin
                            req.stat_we    = 1'b1;
                            req.stat_waddr = slot_reg;
                            req.stat_wdata = ST_READY;
                            ins_next       = slot_reg;
                            push_next      = 1'b0;
                            ret_next       = S_DONE;
                            state_next     = S_INS_A;
                        end
                        else
                            bad_next = 1'b1;
                    end
                    CMD_YIELD:
                    begin
                        if (tgt_st == ST_RUNNING)
                        begin
                            req.stat_we    = 1'b1;
                            req.stat_waddr = cur_reg;
                            req.stat_wdata = ST_READY;
                            ins_next       = cur_reg;
                            push_next      = 1'b0;
                            ret_next       = S_IDLE_RD;
                            state_next     = S_INS_A;
                        end
                        else
                            bad_next = 1'b1;
                    end
                    CMD_BLOCK:
                    begin
                        if (tgt_st == ST_RUNNING && kind_reg <= KIND_HANGING)
                        begin
                            req.stat_we    = 1'b1;
                            req.stat_waddr = cur_reg;
                            req.stat_wdata = block_stat(kind_reg);
                            state_next     = S_IDLE_RD;
                        end
                        else
                            bad_next = 1'b1;
                    end
                    CMD_UNBLOCK:
                    begin
                        if (parked(tgt_st))
                        begin
                            req.stat_we    = 1'b1;
                            req.stat_waddr = slot_reg;
                            req.stat_wdata = ST_READY;
                            ins_next       = slot_reg;
                            push_next      = 1'b1;
                            ret_next       = S_DONE;
                            state_next     = S_INS_A;
                        end
                        else
                            bad_next = 1'b1;
                    end
                    CMD_EXIT:
                    begin
                        if (in_rng(slot_reg) && tgt_st != ST_DIED)
                        begin
                            req.stat_we    = 1'b1;
                            req.stat_waddr = slot_reg;
                            req.stat_wdata = ST_DIED;
                            // status of current is needed by the schedule pass
                            req.stat_re    = resched_reg;
                            req.stat_raddr = cur_reg;
                            if (tgt_st == ST_READY)
                            begin
                                req.link_re    = 1'b1;
                                req.link_raddr = slot_reg;
                                state_next     = S_REMOVE;
                            end
                            else
                                state_next = resched_reg ? S_PASS : S_DONE;
                        end
                        else
                            bad_next = 1'b1;
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end

            S_REMOVE:
            begin
                count_next = count_reg - CW'(1);
                if (slot_reg == head_reg)
                    head_next = rsp.link.next;
                else
                begin
                    req.link_we_next    = 1'b1;
                    req.link_waddr      = rsp.link.prev;
                    req.link_wdata.next = rsp.link.next;
                end
                if (slot_reg == tail_reg)
                begin
                    tail_next  = rsp.link.prev;
                    state_next = resched_reg ? S_PASS : S_DONE;
                end
                else
                    state_next = S_REM_FIX;
            end

            S_REM_FIX:
            begin
                req.link_we_prev    = 1'b1;
                req.link_waddr      = rsp.link.next;
                req.link_wdata.prev = rsp.link.prev;
                state_next          = resched_reg ? S_PASS : S_DONE;
            end

            S_PASS:
            begin
                if (slot_reg != cur_reg && in_rng(cur_reg) && rsp.stat == ST_RUNNING)
                begin
                    req.stat_we    = 1'b1;
                    req.stat_waddr = cur_reg;
                    req.stat_wdata = ST_READY;
                    ins_next       = cur_reg;
                    push_next      = 1'b0;
                    ret_next       = S_IDLE_RD;
                    state_next     = S_INS_A;
                end
                else
                    state_next = S_IDLE_RD;
            end

            S_INS_A:
            begin
                if (count_reg == '0)
                begin
                    head_next  = ins_reg;
                    tail_next  = ins_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ret_reg;
                end
                else if (push_reg)
                begin
                    req.link_we_prev    = 1'b1;
                    req.link_waddr      = head_reg;
                    req.link_wdata.prev = ins_reg;
                    state_next          = S_INS_B;
                end
                else
                begin
                    req.link_we_next    = 1'b1;
                    req.link_waddr      = tail_reg;
                    req.link_wdata.next = ins_reg;
                    state_next          = S_INS_B;
                end
            end

            S_INS_B:
            begin
                req.link_waddr = ins_reg;
                count_next     = count_reg + CW'(1);
                state_next     = ret_reg;
                if (push_reg)
                begin
                    req.link_we_next    = 1'b1;
                    req.link_wdata.next = head_reg;
                    head_next           = ins_reg;
                end
                else
                begin
                    req.link_we_prev    = 1'b1;
                    req.link_wdata.prev = tail_reg;
                    tail_next           = ins_reg;
                end
            end

            S_IDLE_RD:
            begin
                if (count_reg != '0)
                begin
                    req.link_re    = 1'b1;
                    req.link_raddr = head_reg;
                    state_next     = S_POP;
                end
                else
                begin
                    req.stat_re    = 1'b1;
                    req.stat_raddr = cfg_st.idle_slot;
                    state_next     = S_IDLE_CHK;
                end
            end

            S_IDLE_CHK:
            begin
                if (in_rng(cfg_st.idle_slot) && parked(rsp.stat))
                begin
                    req.stat_we    = 1'b1;
                    req.stat_waddr = cfg_st.idle_slot;
                    req.stat_wdata = ST_READY;
                    ins_next       = cfg_st.idle_slot;
                    push_next      = 1'b1;
                    ret_next       = S_POP_RD;
                    state_next     = S_INS_A;
                end
                else
                    state_next = S_DONE;
            end

            S_POP_RD:
            begin
                req.link_re    = 1'b1;
                req.link_raddr = head_reg;
                state_next     = S_POP;
            end

            S_POP:
            begin
                req.stat_we    = 1'b1;
                req.stat_waddr = head_reg;
                req.stat_wdata = ST_RUNNING;
                cur_next       = head_reg;
                head_next      = rsp.link.next;
                count_next     = count_reg - CW'(1);
                sw_next        = 1'b1;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_st.reload)
        begin
            state_next = S_CLEAR;
            clr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ret_reg     <= S_DONE;
            cmd_reg     <= '0;
            slot_reg    <= '0;
            kind_reg    <= '0;
            resched_reg <= 1'b0;
            prev_reg    <= '0;
            cur_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            ins_reg     <= '0;
            push_reg    <= 1'b0;
            sw_reg      <= 1'b0;
            bad_reg     <= 1'b0;
            clr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cmd_reg     <= cmd_next;
            slot_reg    <= slot_next;
            kind_reg    <= kind_next;
            resched_reg <= resched_next;
            prev_reg    <= prev_next;
            cur_reg     <= cur_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            ins_reg     <= ins_next;
            push_reg    <= push_next;
            sw_reg      <= sw_next;
            bad_reg     <= bad_next;
            clr_reg     <= clr_next;
        end
    end

endmodule

`default_nettype wire

// File: design/rqs_out.sv
// Result output register between the sequencer and the result channel.
// Depends on rqs_pkg and rqs_res_if.
`default_nettype none

module rqs_out import rqs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  res_t      res_in,
    output logic      free,
    rqs_res_if.source res
);

    logic valid_reg, valid_next;
    res_t data_reg, data_next;

    assign free       = !valid_reg || res.ready;
    assign valid_next = load || (valid_reg && !res.ready);
    assign data_next  = load ? res_in : data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign res.valid         = valid_reg;
    assign res.running_slot  = data_reg.running_slot;
    assign res.previous_slot = data_reg.previous_slot;
    assign res.switched      = data_reg.switched;
    assign res.outcome       = data_reg.outcome;

endmodule

`default_nettype wire

// File: design/ready_queue_thread_scheduler.sv
// Top level of the round-robin ready queue thread scheduler.
// Depends on rqs_pkg, the channel interfaces, rqs_cfg, rqs_store, rqs_engine, rqs_out.
`default_nettype none

// One command is taken at a time and yields one result. The sequencer handles a
// command by walking the status and link memories, each with one write port and
// a registered read, so queue link updates are made one after another; a finished
// result may then wait in the sequencer until the output register is free. A new
// command is accepted as soon as the sequencer is back in idle, while the previous
// result may still sit in the output register. After reset and after every write
// to idle_slot or boot_slot, a clearing pass over min(MAX_THREADS, 16) slots
// reloads the slot status table; commands are held off until it ends, and after a
// write also while the registered reload request is pending; configuration writes
// are always taken.
module ready_queue_thread_scheduler import rqs_pkg::*;
#(
    parameter int MAX_THREADS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    rqs_cmd_if.sink   cmd,
    rqs_res_if.source res,
    rqs_cfg_if.sink   cfg
);

    cfg_t     cfg_st;
    mem_req_t req;
    mem_rsp_t rsp;
    logic     out_free;
    logic     res_load;
    res_t     res_data;

    rqs_cfg u_cfg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cfg_st (cfg_st)
    );

    rqs_store #(.MAX_THREADS(MAX_THREADS)) u_store
    (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    rqs_engine #(.MAX_THREADS(MAX_THREADS)) u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_st   (cfg_st),
        .rsp      (rsp),
        .req      (req),
        .out_free (out_free),
        .res_load (res_load),
        .res_data (res_data)
    );

    rqs_out u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_load),
        .res_in (res_data),
        .free   (out_free),
        .res    (res)
    );

endmodule

`default_nettype wire

// File: design/rqs_checker.sv
// Port-level checks of the scheduler, bound to the top level.
// Depends on rqs_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rqs_checker import rqs_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [SLOT_W-1:0] res_running_slot,
    input wire logic [SLOT_W-1:0] res_previous_slot,
    input wire logic              res_switched,
    input wire logic              res_outcome
);

    logic                cmd_acc, res_acc, cfg_acc;
    logic [1:0]          pend_reg, pend_next;
    logic [SLOT_W-1:0]   last_run_reg, last_run_next;
    logic                have_last_reg, have_last_next;
    logic [2*SLOT_W+1:0] res_bits;

    assign cmd_acc  = cmd_valid && cmd_ready;
    assign res_acc  = res_valid && res_ready;
    assign cfg_acc  = cfg_valid && cfg_ready;
    assign res_bits = {res_running_slot, res_previous_slot, res_switched, res_outcome};

    assign pend_next      = pend_reg + 2'(cmd_acc) - 2'(res_acc);
    assign last_run_next  = res_acc ? res_running_slot : last_run_reg;
    assign have_last_next = !cfg_acc && (have_last_reg || res_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            last_run_reg  <= '0;
            have_last_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            last_run_reg  <= last_run_next;
            have_last_reg <= have_last_next;
        end
    end

    `RQS_ASSERT(a_no_orphan_result, res_valid, pend_reg != 2'd0)
    `RQS_ASSERT(a_no_overrun, pend_reg == 2'd2, !cmd_ready)
    `RQS_ASSERT(a_slot_kept, res_valid && (res_outcome || !res_switched), res_running_slot == res_previous_slot)
    `RQS_ASSERT(a_slot_chain, res_valid && have_last_reg, res_previous_slot == last_run_reg)
    `RQS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_bits))

endmodule

bind ready_queue_thread_scheduler rqs_checker u_rqs_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_running_slot  (res.running_slot),
    .res_previous_slot (res.previous_slot),
    .res_switched      (res.switched),
    .res_outcome       (res.outcome)
);

`default_nettype wire

// File: tb/tb_ready_queue_thread_scheduler.sv
`timescale 1ns / 1ps
// Testbench of ready_queue_thread_scheduler: a class mirrors the slot table and
// ready deque, predicts one result per command and checks results in order.
// Depends on rqs_pkg, the rqs_*_if interfaces and the scheduler RTL.

module tb_ready_queue_thread_scheduler;
    import rqs_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 31;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 380;
    localparam int TIMEOUT_NS    = 10_000_000;

    localparam logic [CMD_W-1:0]     CMD_RSVD_A   = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_RSVD_B   = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_RSVD_C   = 3'd7;
    localparam logic [KIND_W-1:0]    KIND_INVALID = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd2;
    localparam logic                 OUT_DONE     = 1'b0;
    localparam logic                 OUT_ILLEGAL  = 1'b1;
    localparam logic [SLOT_W-1:0]    RST_IDLE     = 4'd1;
    localparam logic [SLOT_W-1:0]    RST_BOOT     = 4'd0;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [KIND_W-1:0] kind;
        logic              resched;
    } sched_cmd_t;

    typedef enum {PICK_DEAD, PICK_PARKED, PICK_LIVE} pick_t;

    localparam sched_cmd_t DIRECTED [25] = '{
        '{CMD_YIELD,   4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_BLOCK,   4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_START,   4'd15, KIND_BLOCKED, 1'b0},
        '{CMD_START,   4'd2,  KIND_BLOCKED, 1'b0},
        '{CMD_START,   4'd2,  KIND_BLOCKED, 1'b0},
        '{CMD_UNBLOCK, 4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_UNBLOCK, 4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_YIELD,   4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_EXIT,    4'd15, KIND_BLOCKED, 1'b0},
        '{CMD_EXIT,    4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_YIELD,   4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_BLOCK,   4'd0,  KIND_WAITING, 1'b0},
        '{CMD_EXIT,    4'd2,  KIND_BLOCKED, 1'b1},
        '{CMD_BLOCK,   4'd0,  KIND_INVALID, 1'b0},
        '{CMD_BLOCK,   4'd0,  KIND_WAITING, 1'b0},
        '{CMD_BLOCK,   4'd0,  KIND_HANGING, 1'b0},
        '{CMD_EXIT,    4'd1,  KIND_BLOCKED, 1'b1},
        '{CMD_UNBLOCK, 4'd9,  KIND_BLOCKED, 1'b0},
        '{CMD_EXIT,    4'd9,  KIND_BLOCKED, 1'b1},
        '{CMD_RSVD_A,  4'd15, KIND_INVALID, 1'b1},
        '{CMD_RSVD_B,  4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_RSVD_C,  4'd5,  KIND_HANGING, 1'b1},
        '{CMD_START,   4'd1,  KIND_BLOCKED, 1'b0},
        '{CMD_START,   4'd0,  KIND_BLOCKED, 1'b0},
        '{CMD_EXIT,    4'd1,  KIND_BLOCKED, 1'b1}
    };

    class sched_mirror;
        stat_t             status    [SLOT_N];
        logic [SLOT_W-1:0] link_next [SLOT_N];
        logic [SLOT_W-1:0] link_prev [SLOT_N];
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
        logic [SLOT_W-1:0] current;
        logic [SLOT_W-1:0] idle;
        logic [SLOT_W-1:0] boot;
        int unsigned       count;
        res_t              pending [$];
        int unsigned       errors;

        function new();
            idle   = RST_IDLE;
            boot   = RST_BOOT;
            errors = 0;
            reload();
        endfunction

        function void reload();
            for (int i = 0; i < SLOT_N; i++)
            begin
                status[i]    = ST_DIED;
                link_next[i] = '0;
                link_prev[i] = '0;
            end
            head           = '0;
            tail           = '0;
            count          = 0;
            status[idle]   = ST_BLOCKED;
            status[boot]   = ST_RUNNING;
            current        = boot;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SLOT_W-1:0] val);
            if (idx == CFG_IDLE)
                idle = val;
            else if (idx == CFG_BOOT)
                boot = val;
            else
                return;
            reload();
        endfunction

        function bit parked(logic [SLOT_W-1:0] s);
            return status[s] inside {ST_BLOCKED, ST_WAITING, ST_HANGING};
        endfunction

        function void q_append(logic [SLOT_W-1:0] s);
            link_next[s] = '0;
            if (count == 0)
            begin
                head         = s;
                link_prev[s] = '0;
            end
            else
            begin
                link_next[tail] = s;
                link_prev[s]    = tail;
            end
            tail = s;
            count++;
        endfunction

        function void q_push(logic [SLOT_W-1:0] s);
            link_prev[s] = '0;
            if (count == 0)
            begin
                tail         = s;
                link_next[s] = '0;
            end
            else
            begin
                link_prev[head] = s;
                link_next[s]    = head;
            end
            head = s;
            count++;
        endfunction

        function void q_remove(logic [SLOT_W-1:0] s);
            logic [SLOT_W-1:0] p;
            logic [SLOT_W-1:0] n;
            if (count == 0)
                return;
            p = link_prev[s];
            n = link_next[s];
            if (s == head)
                head = n;
            else
                link_next[p] = n;
            if (s == tail)
                tail = p;
            else
                link_prev[n] = p;
            count--;
        endfunction

        // requeue a running current, fall back to idle, pop the head
        function bit run_pass();
            logic [SLOT_W-1:0] s;
            if (status[current] == ST_RUNNING)
            begin
                q_append(current);
                status[current] = ST_READY;
            end
            if (count == 0 && parked(idle))
            begin
                q_push(idle);
                status[idle] = ST_READY;
            end
            if (count == 0)
                return 1'b0;
            s = head;
            q_remove(s);
            status[s] = ST_RUNNING;
            current   = s;
            return 1'b1;
        endfunction

        function void take_command(sched_cmd_t c);
            res_t r;
            r.previous_slot = current;
            r.switched      = 1'b0;
            r.outcome       = OUT_DONE;
            case (c.command)
                CMD_START:
                    if (status[c.slot] == ST_DIED)
                    begin
                        status[c.slot] = ST_READY;
                        q_append(c.slot);
                    end
                    else
                        r.outcome = OUT_ILLEGAL;
                CMD_YIELD:
                    if (status[current] == ST_RUNNING)
                    begin
                        status[current] = ST_READY;
                        q_append(current);
                        r.switched = run_pass();
                    end
                    else
                        r.outcome = OUT_ILLEGAL;
                CMD_BLOCK:
                    if (status[current] == ST_RUNNING && c.kind <= KIND_HANGING)
                    begin
                        status[current] = stat_t'(ST_BLOCKED + c.kind);
                        r.switched = run_pass();
                    end
                    else
                        r.outcome = OUT_ILLEGAL;
                CMD_UNBLOCK:
                    if (parked(c.slot))
                    begin
                        q_push(c.slot);
                        status[c.slot] = ST_READY;
                    end
                    else
                        r.outcome = OUT_ILLEGAL;
                CMD_EXIT:
                    if (status[c.slot] != ST_DIED)
                    begin
                        if (status[c.slot] == ST_READY)
                            q_remove(c.slot);
                        status[c.slot] = ST_DIED;
                        if (c.resched)
                            r.switched = run_pass();
                    end
                    else
                        r.outcome = OUT_ILLEGAL;
                default:
                    r.outcome = OUT_ILLEGAL;
            endcase
            r.running_slot = current;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $display("%0t result with no request outstanding: running %0d previous %0d",
                         $time, got.running_slot, got.previous_slot);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("running_slot", want.running_slot, got.running_slot);
            compare_field("previous_slot", want.previous_slot, got.previous_slot);
            compare_field("switched", want.switched, got.switched);
            compare_field("outcome", want.outcome, got.outcome);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   hold_off;

    sched_mirror mirror = new();

    rqs_cmd_if cmd_ch ();
    rqs_res_if res_ch ();
    rqs_cfg_if cfg_ch ();

    ready_queue_thread_scheduler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial clk = 1'b0;

    always #CLK_HALF clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("ready_queue_thread_scheduler: mismatch");
        $finish;
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
                res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            mirror.check_result(res_t'{res_ch.running_slot, res_ch.previous_slot,
                                       res_ch.switched, res_ch.outcome});

    function automatic logic [SLOT_W-1:0] pick_slot(pick_t want);
        logic [SLOT_W-1:0] found [$];
        for (int i = 0; i < SLOT_N; i++)
            if ((want == PICK_DEAD && mirror.status[i] == ST_DIED) ||
                (want == PICK_PARKED && mirror.parked(i)) ||
                (want == PICK_LIVE && mirror.status[i] != ST_DIED))
                found.push_back(i);
        if (found.size() == 0 || $urandom_range(99) < 20)
            return $urandom_range(SLOT_N - 1);
        return found[$urandom_range(found.size() - 1)];
    endfunction

    function automatic sched_cmd_t random_cmd();
        sched_cmd_t  c;
        int unsigned roll;
        roll      = $urandom_range(99);
        c.slot    = $urandom_range(SLOT_N - 1);
        c.kind    = $urandom_range(KIND_HANGING);
        c.resched = $urandom_range(99) < 60;
        if (roll < 8)
        begin
            c.command = $urandom_range(CMD_RSVD_C);
            c.kind    = $urandom_range(KIND_INVALID);
        end
        else if (roll < 30)
        begin
            c.command = CMD_START;
            c.slot    = pick_slot(PICK_DEAD);
        end
        else if (roll < 50)
            c.command = CMD_YIELD;
        else if (roll < 65)
            c.command = CMD_BLOCK;
        else if (roll < 82)
        begin
            c.command = CMD_UNBLOCK;
            c.slot    = pick_slot(PICK_PARKED);
        end
        else
        begin
            c.command = CMD_EXIT;
            c.slot    = pick_slot(PICK_LIVE);
        end
        return c;
    endfunction

    task automatic send_cmd(input sched_cmd_t c);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= c.command;
        cmd_ch.thread_slot <= c.slot;
        cmd_ch.block_kind  <= c.kind;
        cmd_ch.reschedule  <= c.resched;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        mirror.take_command(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SLOT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        mirror.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (mirror.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.command     <= CMD_START;
        cmd_ch.thread_slot <= '0;
        cmd_ch.block_kind  <= KIND_BLOCKED;
        cmd_ch.reschedule  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_IDLE;
        cfg_ch.data        <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_cmd(DIRECTED[i]);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(CFG_IDLE, '0);
                    write_reg(CFG_BOOT, '1);
                    quiet = 1'b1;
                end
                2:
                begin
                    write_reg(CFG_IDLE, '1);
                    write_reg(CFG_BOOT, '0);
                    hold_off = 1'b1;
                end
                3:
                begin
                    write_reg(CFG_IDLE, 4'd7);
                    write_reg(CFG_BOOT, 4'd7);
                end
                4:
                begin
                    write_reg(CFG_UNUSED, $urandom_range(SLOT_N - 1));
                    write_reg(CFG_IDLE, $urandom_range(SLOT_N - 1));
                    write_reg(CFG_BOOT, $urandom_range(SLOT_N - 1));
                end
                default: ;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_cmd(random_cmd());
            drain();
            quiet = 1'b0;
        end

        if (mirror.errors == 0 && mirror.pending.size() == 0)
            $display("ready_queue_thread_scheduler: match");
        else
            $display("ready_queue_thread_scheduler: mismatch");
        $finish;
    end

endmodule
